@@ hw/rtl/spd_pkg.sv @@
// spd_pkg: shared types, status codes and hex helper for the percent decoder
// used by every module of the decoder core; no dependencies
`default_nettype none

package spd_pkg;

    localparam int unsigned CFG_RESET  = 4096;
    localparam logic [7:0]  CHAR_PCT   = 8'h25;
    localparam logic [7:0]  CTRL_LIMIT = 8'h20;
    localparam logic [7:0]  CHAR_DEL   = 8'h7F;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_HEX   = 3'd1,
        ST_CONTROL   = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_EMPTY     = 3'd4,
        ST_TRUNCATED = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_HIGH  = 2'd1,
        PH_LOW   = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       value_end;
        status_t    status;
    } result_t;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        return v;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/strict_percent_decoder_core.sv @@
// strict_percent_decoder_core: top level of the strict percent decoder
// depends on spd_pkg, spd_in_reg, spd_step, spd_out_reg
//
//  channel | direction | ports                                      | handshake
//  s_      | in        | s_in_byte, s_in_last                       | s_valid / s_ready
//  m_      | out       | m_out_byte, m_byte_valid, m_value_end, m_status | m_valid / m_ready
//  cfg_    | in        | cfg_data (max decoded length)              | cfg_valid / cfg_ready
//
// one word per cycle sustained unless the result register is stalled by m_ready
// the input register feeds the decode logic, which writes the result register
// words that give no result are consumed without touching the output
// s_ready falls only while a word is held and the result register is stalled
// synchronous active-low reset clears valid bits and decode state; limit returns to 4096, clamped to MAX_LEN_LIMIT
`default_nettype none

module strict_percent_decoder_core #(
    parameter int unsigned MAX_LEN_LIMIT = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_in_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_value_end,
    output logic [2:0]       m_status,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [12:0] cfg_data
);
    import spd_pkg::*;

    localparam logic [16:0] LIMIT_W = 17'(MAX_LEN_LIMIT);

    function automatic logic [12:0] clamp(input logic [12:0] d);
        return ({4'b0, d} > LIMIT_W) ? LIMIT_W[12:0] : d;
    endfunction

    logic [12:0] limit_reg;
    item_t       s_item, item;
    logic        item_valid, advance, fire, res_valid;
    result_t     res, m_res;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= clamp(13'(CFG_RESET));
        end else if (cfg_valid && cfg_ready) begin
            limit_reg <= clamp(cfg_data);
        end
    end

    assign s_item.in_byte = s_in_byte;
    assign s_item.in_last = s_in_last;
    assign fire           = item_valid && advance;

    spd_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    spd_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (item),
        .limit     (limit_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    spd_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .res_valid (res_valid),
        .res       (res),
        .m_ready   (m_ready),
        .advance   (advance),
        .m_valid   (m_valid),
        .m_res     (m_res)
    );

    assign m_out_byte   = m_res.out_byte;
    assign m_byte_valid = m_res.byte_valid;
    assign m_value_end  = m_res.value_end;
    assign m_status     = m_res.status;

    a_status_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_value_end |-> m_status == ST_OK)
        else $error("status set on a word that does not close the value");

    a_empty_word_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_byte_valid |-> m_value_end && m_out_byte == 8'h00)
        else $error("result without a byte that does not close the value");

    a_no_control_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> m_out_byte >= CTRL_LIMIT && m_out_byte != CHAR_DEL)
        else $error("control byte emitted");

    a_byte_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid && m_value_end |-> m_status != ST_EMPTY)
        else $error("empty status with a decoded byte");

endmodule

`default_nettype wire

@@ hw/rtl/spd_in_reg.sv @@
// spd_in_reg: input pipeline register holding one encoded word
// depends on spd_pkg
`default_nettype none

module spd_in_reg (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire spd_pkg::item_t s_item,
    input  wire logic          advance,
    output logic               item_valid,
    output spd_pkg::item_t     item
);
    import spd_pkg::*;

    logic  valid_reg, valid_next;
    item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

@@ hw/rtl/spd_step.sv @@
// spd_step: escape state, error latch, byte count and per-word decode logic
// depends on spd_pkg
`default_nettype none

module spd_step (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire spd_pkg::item_t   item,
    input  wire logic [12:0]      limit,
    output logic                  res_valid,
    output spd_pkg::result_t      res
);
    import spd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hi_reg, hi_next;
    logic [12:0] count_reg, count_next;
    status_t     err_reg, err_next;

    logic [4:0]  hv;
    logic        cand;
    logic        have;
    logic [7:0]  dbyte;

    assign hv = hex_val(item.in_byte);

    // next state
    always_comb begin
        phase_next = phase_reg;
        hi_next    = hi_reg;
        count_next = count_reg;
        err_next   = err_reg;
        cand       = 1'b0;
        have       = 1'b0;
        dbyte      = item.in_byte;
        if (err_reg == ST_OK) begin
            case (phase_reg)
                PH_PLAIN: begin
                    if (item.in_byte == CHAR_PCT) begin
                        phase_next = PH_HIGH;
                        if (item.in_last) begin
                            err_next = ST_TRUNCATED;
                        end
                    end else begin
                        cand = 1'b1;
                    end
                end
                PH_HIGH: begin
                    if (item.in_last) begin
                        err_next = ST_TRUNCATED;
                    end else if (hv[4]) begin
                        err_next = ST_BAD_HEX;
                    end else begin
                        hi_next    = hv[3:0];
                        phase_next = PH_LOW;
                    end
                end
                PH_LOW: begin
                    phase_next = PH_PLAIN;
                    if (hv[4]) begin
                        err_next = ST_BAD_HEX;
                    end else begin
                        cand  = 1'b1;
                        dbyte = {hi_reg, hv[3:0]};
                    end
                end
                default: begin
                    phase_next = PH_PLAIN;
                end
            endcase
            if (cand) begin
                if (dbyte < CTRL_LIMIT || dbyte == CHAR_DEL) begin
                    err_next = ST_CONTROL;
                end else if (count_reg >= limit) begin
                    err_next = ST_TOO_LONG;
                end else begin
                    count_next = count_reg + 13'd1;
                    have       = 1'b1;
                end
            end
        end
    end

    // result
    always_comb begin
        res_valid      = item.in_last || have;
        res.out_byte   = have ? dbyte : 8'h00;
        res.byte_valid = have;
        res.value_end  = item.in_last;
        res.status     = ST_OK;
        if (item.in_last) begin
            if (err_next == ST_OK && count_next == 13'd0) begin
                res.status = ST_EMPTY;
            end else begin
                res.status = err_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_PLAIN;
            hi_reg    <= 4'h0;
            count_reg <= 13'd0;
            err_reg   <= ST_OK;
        end else if (fire) begin
            if (item.in_last) begin
                phase_reg <= PH_PLAIN;
                hi_reg    <= 4'h0;
                count_reg <= 13'd0;
                err_reg   <= ST_OK;
            end else begin
                phase_reg <= phase_next;
                hi_reg    <= hi_next;
                count_reg <= count_next;
                err_reg   <= err_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/spd_out_reg.sv @@
// spd_out_reg: result register on the output channel
// depends on spd_pkg
`default_nettype none

module spd_out_reg (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             fire,
    input  wire logic             res_valid,
    input  wire spd_pkg::result_t res,
    input  wire logic             m_ready,
    output logic                  advance,
    output logic                  m_valid,
    output spd_pkg::result_t      m_res
);
    import spd_pkg::*;

    logic    valid_reg, valid_next;
    result_t res_reg;

    assign advance    = !valid_reg || m_ready;
    assign valid_next = advance ? (fire && res_valid) : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule

`default_nettype wire

@@ tb/strict_percent_decoder_core_test.sv @@
// strict_percent_decoder_core_test: self-checking bench for the strict percent decoder core
// drives encoded words with random gaps and stalls, predicts each result word and compares
// depends on spd_pkg and strict_percent_decoder_core
`timescale 1ns / 1ps

module strict_percent_decoder_core_test;

    import spd_pkg::*;

    localparam int unsigned LEN_CAP = 4096;

    typedef struct {
        item_t word;
        bit    hold;
    } queued_char_t;

    logic        aclk;
    logic        aresetn      = 1'b0;
    logic        s_valid      = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte    = 8'h00;
    logic        s_in_last    = 1'b0;
    logic        m_valid;
    logic        m_ready      = 1'b0;
    logic [7:0]  m_out_byte;
    logic        m_byte_valid;
    logic        m_value_end;
    logic [2:0]  m_status;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [12:0] cfg_data     = 13'd0;

    // encoded characters waiting to be sent, decoded words still owed by the core
    queued_char_t chars_q[$];
    result_t      decoded_q[$];

    // predictor state
    logic [12:0] lim_q   = 13'(CFG_RESET);
    phase_t      phase_q = PH_PLAIN;
    logic [3:0]  hi_q    = 4'h0;
    logic [12:0] count_q = 13'd0;
    status_t     err_q   = ST_OK;

    bit          s_accepted = 1'b0;
    bit          m_taken    = 1'b0;
    bit          s_idle_on  = 1'b0;
    bit          m_idle_on  = 1'b0;
    int unsigned s_gap      = 0;
    int unsigned m_stall    = 0;
    int unsigned chars_queued = 0;
    int unsigned words_in   = 0;
    int unsigned words_out  = 0;
    int unsigned values_out = 0;
    int unsigned fails      = 0;
    int unsigned status_hits[6];

    strict_percent_decoder_core #(
        .MAX_LEN_LIMIT(LEN_CAP)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_byte   (s_in_byte),
        .s_in_last   (s_in_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_byte_valid(m_byte_valid),
        .m_value_end (m_value_end),
        .m_status    (m_status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // bit 4 set: not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] f;
        f = c | 8'h20;
        if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
        if (f >= "a" && f <= "f") return {1'b0, 4'(c[3:0] + 4'd9)};
        return 5'h10;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return 8'h30 + 8'(n);
        return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + 8'(n);
    endfunction

    task automatic decode_word(input logic [7:0] c, input logic fin);
        result_t     r;
        logic        emit;
        logic [7:0]  b;
        logic [4:0]  h;
        logic [12:0] cap;
        emit = 1'b0;
        b = 8'h00;
        cap = (lim_q > 13'(LEN_CAP)) ? 13'(LEN_CAP) : lim_q;
        if (err_q == ST_OK) begin
            case (phase_q)
                PH_PLAIN: begin
                    if (c == CHAR_PCT) begin
                        phase_q = PH_HIGH;
                        if (fin) err_q = ST_TRUNCATED;
                    end else begin
                        emit = 1'b1;
                        b = c;
                    end
                end
                PH_HIGH: begin
                    h = nibble_of(c);
                    if (fin) begin
                        err_q = ST_TRUNCATED;
                    end else if (h[4]) begin
                        err_q = ST_BAD_HEX;
                    end else begin
                        hi_q = h[3:0];
                        phase_q = PH_LOW;
                    end
                end
                default: begin
                    h = nibble_of(c);
                    phase_q = PH_PLAIN;
                    if (h[4]) begin
                        err_q = ST_BAD_HEX;
                    end else begin
                        emit = 1'b1;
                        b = {hi_q, h[3:0]};
                    end
                end
            endcase
            if (emit) begin
                if (b < CTRL_LIMIT || b == CHAR_DEL) err_q = ST_CONTROL;
                else if (count_q >= cap) err_q = ST_TOO_LONG;
                else count_q++;
                if (err_q != ST_OK) emit = 1'b0;
            end
        end
        if (emit || fin) begin
            r.out_byte   = emit ? b : 8'h00;
            r.byte_valid = emit;
            r.value_end  = fin;
            r.status     = ST_OK;
            if (fin) begin
                r.status = (err_q == ST_OK && count_q == 0) ? ST_EMPTY : err_q;
                phase_q = PH_PLAIN;
                hi_q = 4'h0;
                count_q = 13'd0;
                err_q = ST_OK;
            end
            decoded_q.push_back(r);
        end
    endtask

    task automatic queue_char(input logic [7:0] b, input logic fin, input bit hold);
        queued_char_t q;
        q.word.in_byte = b;
        q.word.in_last = fin;
        q.hold = hold;
        chars_q.push_back(q);
        chars_queued++;
    endtask

    // mostly well-formed text and escapes, some raw noise and broken escapes
    task automatic queue_value(input int unsigned units);
        int unsigned k;
        int unsigned pick;
        logic [7:0]  b;
        bit          fin;
        bit          hold;
        hold = ($urandom_range(0, 39) == 0);
        for (k = 0; k < units; k++) begin
            fin = (k + 1 == units);
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                b = 8'($urandom_range(8'h20, 8'h7e));
                if (b == CHAR_PCT) b = "+";
                queue_char(b, fin, hold);
            end else if (pick < 85) begin
                b = (pick < 80) ? 8'($urandom_range(8'h20, 8'hfe)) : 8'($urandom_range(0, 255));
                queue_char(CHAR_PCT, 1'b0, hold);
                queue_char(hex_char(b[7:4]), 1'b0, 1'b0);
                queue_char(hex_char(b[3:0]), fin, 1'b0);
            end else if (pick < 93) begin
                queue_char(8'($urandom_range(0, 255)), fin, hold);
            end else if (fin && $urandom_range(0, 1)) begin
                queue_char(CHAR_PCT, 1'b1, hold);
            end else begin
                queue_char(CHAR_PCT, 1'b0, hold);
                queue_char(8'($urandom_range(0, 255)), fin, 1'b0);
            end
            hold = 1'b0;
        end
    endtask

    task automatic random_phase(input int unsigned budget, input int unsigned max_units);
        int unsigned stop_at;
        stop_at = chars_queued + budget;
        s_idle_on = $urandom_range(0, 3) != 0;
        m_idle_on = $urandom_range(0, 3) != 0;
        while (chars_queued < stop_at) queue_value($urandom_range(1, max_units));
    endtask

    task automatic queue_run(input int unsigned n);
        int unsigned k;
        for (k = 0; k < n; k++) queue_char(8'($urandom_range(8'h30, 8'h7a)), k + 1 == n, 1'b0);
    endtask

    // everything sent and answered, then an idle wait for words that give no result
    task automatic settle();
        while (chars_q.size() != 0 || s_valid || decoded_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [12:0] v);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        lim_q = v;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // input word driver
    always @(negedge aclk) begin : drive_chars
        queued_char_t nxt;
        logic         v_n;
        logic [7:0]   b_n;
        logic         l_n;
        v_n = s_valid;
        b_n = s_in_byte;
        l_n = s_in_last;
        if (!aresetn) begin
            v_n = 1'b0;
        end else if (!s_valid || s_accepted) begin
            if (s_accepted) begin
                s_accepted = 1'b0;
                s_gap = s_idle_on ? $urandom_range(0, 15) : 0;
            end
            v_n = 1'b0;
            if (s_gap > 0) begin
                s_gap--;
            end else if (chars_q.size() > 0 && (!chars_q[0].hold || decoded_q.size() == 0)) begin
                nxt = chars_q.pop_front();
                v_n = 1'b1;
                b_n = nxt.word.in_byte;
                l_n = nxt.word.in_last;
            end
        end
        s_valid   <= v_n;
        s_in_byte <= b_n;
        s_in_last <= l_n;
    end

    // result back-pressure
    always @(negedge aclk) begin
        if (m_taken) begin
            m_taken = 1'b0;
            m_stall = m_idle_on ? $urandom_range(0, 15) : 0;
        end
        if (m_stall > 0) begin
            m_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : watch
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                m_taken = 1'b1;
                words_out++;
                if (decoded_q.size() == 0) begin
                    $error("result word with nothing owed: out_byte %0h status %0d",
                           m_out_byte, m_status);
                    fails++;
                end else begin
                    want = decoded_q.pop_front();
                    if (want.value_end) begin
                        values_out++;
                        status_hits[int'(want.status)]++;
                    end
                    if (m_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, m_out_byte);
                        fails++;
                    end
                    if (m_byte_valid !== want.byte_valid) begin
                        $error("byte_valid: expected %0d, got %0d", want.byte_valid, m_byte_valid);
                        fails++;
                    end
                    if (m_value_end !== want.value_end) begin
                        $error("value_end: expected %0d, got %0d", want.value_end, m_value_end);
                        fails++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_status);
                        fails++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                decode_word(s_in_byte, s_in_last);
                s_accepted = 1'b1;
                words_in++;
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset limit: plain, escapes of both cases, extremes, bad hex, control and truncated faults
        s_idle_on = 1'b1;
        m_idle_on = 1'b1;
        queue_char("A", 1'b1, 1'b0);
        queue_char(CHAR_PCT, 1'b0, 1'b0);
        queue_char("4", 1'b0, 1'b0);
        queue_char("a", 1'b0, 1'b0);
        queue_char(CHAR_PCT, 1'b0, 1'b0);
        queue_char("6", 1'b0, 1'b0);
        queue_char("F", 1'b0, 1'b0);
        queue_char(8'hff, 1'b1, 1'b0);
        queue_char(8'h00, 1'b1, 1'b0);
        queue_char(CHAR_PCT, 1'b0, 1'b1);
        queue_char("7", 1'b0, 1'b0);
        queue_char("F", 1'b1, 1'b0);
        queue_char(CHAR_PCT, 1'b0, 1'b0);
        queue_char("g", 1'b0, 1'b0);
        queue_char("x", 1'b1, 1'b0);
        queue_char(CHAR_PCT, 1'b0, 1'b0);
        queue_char("4", 1'b0, 1'b0);
        queue_char("G", 1'b1, 1'b0);
        queue_char(CHAR_PCT, 1'b1, 1'b0);
        queue_char(CHAR_PCT, 1'b0, 1'b0);
        queue_char("4", 1'b1, 1'b0);
        queue_char(CHAR_PCT, 1'b0, 1'b0);
        queue_char("Z", 1'b1, 1'b0);

        // zero limit: control wins over too long, every other decoded byte too long
        write_limit(13'd0);
        queue_char(8'h1f, 1'b1, 1'b0);
        queue_char("a", 1'b1, 1'b0);
        queue_char(CHAR_PCT, 1'b0, 1'b0);
        queue_char("4", 1'b0, 1'b0);
        queue_char("1", 1'b1, 1'b0);
        random_phase(30, 3);

        write_limit(13'd1);
        random_phase(80, 3);

        // above the cap acts as the cap, no idling
        write_limit(13'h1fff);
        s_idle_on = 1'b0;
        m_idle_on = 1'b0;
        queue_run(64);

        write_limit(13'(LEN_CAP));
        s_idle_on = 1'b0;
        m_idle_on = 1'b0;
        queue_run(64);
        random_phase(180, 8);

        write_limit(13'd3);
        random_phase(100, 5);

        write_limit(13'd2048);
        random_phase(100, 20);

        write_limit(13'($urandom_range(1, 40)));
        random_phase(100, 12);

        settle();
        $display("%0d words sent, %0d result words checked, %0d values closed",
                 words_in, words_out, values_out);
        $display("limits 0 to 8191; ok %0d, bad hex %0d, control %0d, too long %0d, truncated %0d",
                 status_hits[ST_OK], status_hits[ST_BAD_HEX], status_hits[ST_CONTROL],
                 status_hits[ST_TOO_LONG], status_hits[ST_TRUNCATED]);
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ strict_percent_decoder_core.f @@
hw/rtl/spd_pkg.sv
hw/rtl/spd_in_reg.sv
hw/rtl/spd_step.sv
hw/rtl/spd_out_reg.sv
hw/rtl/strict_percent_decoder_core.sv
tb/strict_percent_decoder_core_test.sv
